@@ rtl/core/g16ra_pkg.sv @@
// Package: GF(16) arithmetic, parity graph builder and sequencer microcode for the encoder.
package g16ra_pkg;

	localparam int InfoSyms    = 13;
	localparam int MaxReps     = 3;
	localparam int MaxStages   = InfoSyms * MaxReps;
	localparam int DefReplicas = 2;
	localparam int SymW        = 4;
	localparam int PosW        = 6;
	localparam int InfoIdxW    = $clog2(InfoSyms);
	localparam int StageIdxW   = $clog2(MaxStages);
	localparam int StepW       = 2;
	localparam int NumSteps    = 1 << StepW;
	localparam int WeightWrap  = 14;
	localparam logic [4:0] GfPoly = 5'h13;

	// Data source for the output word
	typedef enum logic [1:0] {
		SRC_NONE   = 2'd0,
		SRC_INFO   = 2'd1,
		SRC_PARITY = 2'd2
	} src_t;

	// Jump condition of a microcode step
	typedef enum logic [1:0] {
		COND_IN_ACCEPT = 2'd0,
		COND_INFO_END  = 2'd1,
		COND_SYM_END   = 2'd2,
		COND_NEVER     = 2'd3
	} cond_t;

	typedef logic [StepW-1:0] step_t;

	typedef struct packed {
		logic  load;
		src_t  src;
		cond_t cond;
		step_t target;
	} ctrl_word_t;

	// Status from the datapath to the sequencer
	typedef struct packed {
		logic in_fire;
		logic emit;
		logic info_end;
		logic sym_end;
	} seq_status_t;

	localparam step_t StepLoad   = 2'd0;
	localparam step_t StepInfo   = 2'd1;
	localparam step_t StepParity = 2'd2;

	// Microcode: load a message, send info symbols, send parity symbols
	localparam ctrl_word_t Microcode [NumSteps] = '{
		'{load: 1'b1, src: SRC_NONE,   cond: COND_IN_ACCEPT, target: StepInfo},
		'{load: 1'b0, src: SRC_INFO,   cond: COND_INFO_END,  target: StepParity},
		'{load: 1'b0, src: SRC_PARITY, cond: COND_SYM_END,   target: StepLoad},
		'{load: 1'b0, src: SRC_NONE,   cond: COND_NEVER,     target: StepLoad}
	};

	typedef struct packed {
		logic [MaxStages-1:0][InfoIdxW-1:0] info;
		logic [MaxStages-1:0][SymW-1:0]     wgt;
	} graph_t;

	// alpha^e over x^4+x+1
	function automatic logic [SymW-1:0] gf_exp(int e);
		logic [4:0] x;
		x = 5'd1;
		for (int i = 0; i < e; i++) begin
			x = x << 1;
			if (x[4]) begin
				x = x ^ GfPoly;
			end
		end
		return x[SymW-1:0];
	endfunction

	// GF(16) product: carry-less multiply, then reduce
	function automatic logic [SymW-1:0] gf_mul(logic [SymW-1:0] a, logic [SymW-1:0] b);
		logic [6:0] p;
		p = '0;
		for (int i = 0; i < SymW; i++) begin
			if (b[i]) begin
				p = p ^ (7'(a) << i);
			end
		end
		for (int k = 6; k >= SymW; k--) begin
			if (p[k]) begin
				p = p ^ (7'(GfPoly) << (k - SymW));
			end
		end
		return p[SymW-1:0];
	endfunction

	// Interleaver and weight tables; a coprime stride hits each stage exactly once
	function automatic graph_t build_graph(int reps);
		graph_t g;
		int stride;
		int nc;
		int stage;
		int k;
		logic [SymW-1:0] wsum;
		logic [SymW-1:0] wval;
		g      = '0;
		stride = (reps == 1) ? 12 : 11;
		nc     = InfoSyms * reps;
		stage  = 0;
		k      = 0;
		for (int i = 0; i < InfoSyms; i++) begin
			wsum = '0;
			for (int r = 0; r < reps; r++) begin
				if (r + 1 < reps) begin
					wval = gf_exp(1 + k);
					wsum = wsum ^ wval;
				end else begin
					wval = (wsum == '0) ? SymW'(1) : wsum;
				end
				g.info[stage] = InfoIdxW'(i);
				g.wgt[stage]  = wval;
				k = (k == WeightWrap - 1) ? 0 : k + 1;
				stage = stage + stride;
				if (stage >= nc) begin
					stage = stage - nc;
				end
			end
		end
		return g;
	endfunction

endpackage

@@ rtl/core/gf16_repeat_accumulate_encoder_top.sv @@
// Top level: GF(16) repeat-accumulate encoder, one tone per output word.
//
//   channel | handshake           | payload
//   --------+---------------------+-------------------------------------
//   in      | in_valid / in_ready | frame_type, payload_bits, check_bits
//   out     | out_valid/out_ready | tone, position, last
//
// A message is one load step and then 13*(REPLICAS+1) output words. Unless the
// output stalls, the sequencer issues one symbol per cycle from a single step per
// codeword section; the accumulator likewise folds one parity stage per cycle.
// Reset clears the step counter and the output valid; the message is taken only
// in the load step. A low out_ready holds a pending word and the sequencer.
module gf16_repeat_accumulate_encoder_top
	import g16ra_pkg::*;
#(
	parameter int REPLICAS = DefReplicas
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          frame_type,
	input  logic [37:0]         payload_bits,
	input  logic [11:0]         check_bits,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [SymW-1:0]     tone,
	output logic [PosW-1:0]     position,
	output logic                last
);

	localparam int Reps = (REPLICAS < 1) ? 1 : ((REPLICAS > MaxReps) ? MaxReps : REPLICAS);
	localparam logic [PosW-1:0] LastPos  = PosW'(InfoSyms * (Reps + 1) - 1);
	localparam logic [PosW-1:0] InfoLast = PosW'(InfoSyms - 1);
	localparam logic [PosW-1:0] InfoSymsP = PosW'(InfoSyms);
	localparam graph_t Graph = build_graph(Reps);

	ctrl_word_t  ctrl;
	seq_status_t status;

	logic [SymW-1:0]      nib_q [InfoSyms];
	logic [SymW-1:0]      acc_q;
	logic [PosW-1:0]      pos_q;
	logic                 out_valid_q;
	logic [SymW-1:0]      tone_q;
	logic [PosW-1:0]      position_q;
	logic                 last_q;

	logic                 in_fire;
	logic                 issue_ok;
	logic                 emit;
	logic [PosW-1:0]      stage_full;
	logic [StageIdxW-1:0] stage_idx;
	logic [SymW-1:0]      acc_next;
	logic [51:0]          msg;

	g16ra_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	// Handshake and issue control
	assign in_ready = ctrl.load;
	assign in_fire  = in_valid && in_ready;
	assign issue_ok = out_ready || !out_valid_q;
	assign emit     = (ctrl.src != SRC_NONE) && issue_ok;

	assign status.in_fire  = in_fire;
	assign status.emit     = emit;
	assign status.info_end = (pos_q == InfoLast);
	assign status.sym_end  = (pos_q == LastPos);

	// Fold the interleaved info symbol times its weight into the accumulator
	assign msg        = {frame_type, payload_bits, check_bits};
	assign stage_full = pos_q - InfoSymsP;
	assign stage_idx  = stage_full[StageIdxW-1:0];
	assign acc_next   = acc_q ^ gf_mul(Graph.wgt[stage_idx], nib_q[Graph.info[stage_idx]]);

	// Latch the info nibbles MSB-first
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int s = 0; s < InfoSyms; s++) begin
				nib_q[s] <= msg[51 - 4 * s -: SymW];
			end
		end
	end

	// Advance the symbol counter and parity accumulator
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (in_fire) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (emit) begin
			if (ctrl.src == SRC_PARITY) begin
				acc_q <= acc_next;
			end
			pos_q <= pos_q + PosW'(1);
		end
	end

	// Output register: load a word when free or being taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			tone_q     <= (ctrl.src == SRC_INFO) ? nib_q[pos_q[InfoIdxW-1:0]] : acc_next;
			position_q <= pos_q;
			last_q     <= (pos_q == LastPos);
		end
	end

	assign out_valid = out_valid_q;
	assign tone      = tone_q;
	assign position  = position_q;
	assign last      = last_q;

endmodule

@@ rtl/core/g16ra_sequencer.sv @@
// Microcode sequencer: step counter, control ROM and conditional jumps.
module g16ra_sequencer
	import g16ra_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  seq_status_t status,
	output ctrl_word_t  ctrl
);

	step_t step_q;
	logic  jump;

	// Fetch the control word of the current step
	assign ctrl = Microcode[step_q];

	// Evaluate the jump condition
	always_comb begin
		case (ctrl.cond)
			COND_IN_ACCEPT: jump = status.in_fire;
			COND_INFO_END:  jump = status.emit && status.info_end;
			COND_SYM_END:   jump = status.emit && status.sym_end;
			default:        jump = 1'b0;
		endcase
	end

	// Jump on condition, otherwise hold the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= StepLoad;
		end else if (jump) begin
			step_q <= ctrl.target;
		end
	end

endmodule
